FILE: src/ple_pkg.sv
// shared types, codes and sizes for the positional list engine
`timescale 1ns / 1ps
package ple_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int IDX_W    = 8;

   localparam logic [IDX_W-1:0] NO_INDEX = {IDX_W{1'b1}};

   typedef enum logic [2:0] {
      REQ_APPEND       = 3'd0,
      REQ_INSERT       = 3'd1,
      REQ_REMOVE_AT    = 3'd2,
      REQ_REMOVE_MATCH = 3'd3,
      REQ_GET          = 3'd4,
      REQ_SET          = 3'd5,
      REQ_FIND         = 3'd6,
      REQ_CLEAR        = 3'd7
   } req_type_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WALK_NONE = 2'd0,
      WALK_SCAN = 2'd1,
      WALK_DOWN = 2'd2,
      WALK_UP   = 2'd3
   } walk_type;

   typedef struct packed {
      logic     load;
      walk_type walk;
      logic     scan_go;
      logic     dn_go;
      logic     dn_from_lag;
      logic     up_go;
      logic     read_pos;
      logic     capture;
      logic     write_val;
      logic     cnt_inc;
      logic     cnt_dec;
      logic     cnt_clr;
      logic     set_miss;
      logic     set_full;
      logic     set_idx;
      logic     finish;
   } ple_cmd_type;

   typedef struct packed {
      req_type_type op;
      logic         full;
      logic         pos_le_cnt;
      logic         pos_lt_cnt;
      logic         hit;
      logic         fwd_more;
      logic         up_more;
      logic         rd_vld;
   } ple_stat_type;

endpackage

FILE: src/positional_list_engine_core.sv
// top level of the positional list engine
`timescale 1ns / 1ps
// An ordered list of up to 64 signed 32-bit words with append, insert, remove at a
// position, remove first match, get, set, find and clear. A request word is taken
// when start is high and busy is low; exactly one result word follows, shown for one
// cycle with rsp_strobe, and cannot be held off by the receiver. Busy falls in the
// cycle the result appears, so the next request may be taken then. Set, clear and
// every refused request go straight to the result; get reads the word at the
// position; append, or insert, moves the entries from the end down to the position
// up by one and then writes the new word; remove at a position moves the entries
// above it down by one; find scans from the start to the first match; and remove
// first match scans to the match and then moves the entries above it down. The
// list sits in a memory with one read and one write port, and scans and shifts move
// one entry per cycle, overlapped with the read latency.
module positional_list_engine_core import ple_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_type,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   output logic                    rsp_strobe,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic signed [IDX_W-1:0] rsp_result_index,
   output logic [1:0]              rsp_status,
   output logic [CNT_W-1:0]        rsp_list_count
);

   ple_cmd_type  cmd;
   ple_stat_type stat;

   ple_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   ple_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_position     (req_position),
      .req_item_value   (req_item_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status),
      .rsp_list_count   (rsp_list_count)
   );

endmodule

FILE: src/ple_ctrl.sv
// request sequencer for the positional list engine
`timescale 1ns / 1ps
module ple_ctrl import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ple_stat_type stat,
   output logic         busy,
   output ple_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_CHECK    = 7'b0000010,
      S_SCAN     = 7'b0000100,
      S_SHIFT_DN = 7'b0001000,
      S_SHIFT_UP = 7'b0010000,
      S_GETW     = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.walk = WALK_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
            case (stat.op)
               REQ_APPEND, REQ_INSERT: begin
                  if (!stat.pos_le_cnt) begin
                     cmd.set_miss = 1'b1;
                  end else if (stat.full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.up_go = 1'b1;
                     state_in  = S_SHIFT_UP;
                  end
               end
               REQ_REMOVE_AT: begin
                  if (stat.pos_lt_cnt) begin
                     cmd.dn_go = 1'b1;
                     state_in  = S_SHIFT_DN;
                  end else begin
                     cmd.set_miss = 1'b1;
                  end
               end
               REQ_REMOVE_MATCH, REQ_FIND: begin
                  cmd.scan_go = 1'b1;
                  state_in    = S_SCAN;
               end
               REQ_GET: begin
                  if (stat.pos_lt_cnt) begin
                     cmd.read_pos = 1'b1;
                     state_in     = S_GETW;
                  end else begin
                     cmd.set_miss = 1'b1;
                  end
               end
               REQ_SET: begin
                  if (stat.pos_lt_cnt) begin
                     cmd.write_val = 1'b1;
                  end else begin
                     cmd.set_miss = 1'b1;
                  end
               end
               default: begin
                  cmd.cnt_clr = 1'b1;
               end
            endcase
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.op == REQ_FIND) begin
                  cmd.set_idx = 1'b1;
                  state_in    = S_DONE;
               end else begin
                  cmd.dn_from_lag = 1'b1;
                  state_in        = S_SHIFT_DN;
               end
            end else begin
               cmd.walk = WALK_SCAN;
               if (!stat.fwd_more && !stat.rd_vld) begin
                  cmd.set_miss = 1'b1;
                  state_in     = S_DONE;
               end
            end
         end
         S_SHIFT_DN: begin
            cmd.walk = WALK_DOWN;
            if (!stat.fwd_more && !stat.rd_vld) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_SHIFT_UP: begin
            cmd.walk = WALK_UP;
            if (!stat.up_more && !stat.rd_vld) begin
               cmd.write_val = 1'b1;
               cmd.cnt_inc   = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_GETW: begin
            cmd.capture = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: src/ple_datapath.sv
// list storage, walk pointers, count and result registers
`timescale 1ns / 1ps
module ple_datapath import ple_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  ple_cmd_type             cmd,
   output ple_stat_type            stat,
   input  logic [2:0]              req_type,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   output logic                    rsp_strobe,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic signed [IDX_W-1:0] rsp_result_index,
   output logic [1:0]              rsp_status,
   output logic [CNT_W-1:0]        rsp_list_count
);

   logic [VAL_W-1:0]  mem [CAPACITY];
   logic [VAL_W-1:0]  rdata_ff;

   req_type_type      op_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0] left_ff, left_in;
   logic [ADDR_W-1:0] lag_ff;
   logic              rd_vld_ff;
   logic [VAL_W-1:0]  rval_ff, rval_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   status_type        status_ff, status_in;

   logic              rsp_strobe_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              issue;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              fwd_more;
   logic              up_more;
   logic              dn_keep;

   assign fwd_more = (ptr_ff < count_ff);
   assign up_more  = (left_ff != '0);
   assign dn_keep  = rd_vld_ff && (lag_ff == pos_ff[ADDR_W-1:0]);

   always_comb begin
      case (cmd.walk)
         WALK_SCAN, WALK_DOWN: issue = fwd_more;
         WALK_UP:              issue = up_more;
         default:              issue = 1'b0;
      endcase
   end

   assign rd_en   = issue || cmd.read_pos;
   assign rd_addr = cmd.read_pos ? pos_ff[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];

   // effective position is fixed when the word is taken; remove first match later sets it to the match
   always_comb begin
      case (req_type_type'(req_type))
         REQ_APPEND:    pos_in = POS_W'(count_ff);
         REQ_INSERT:    pos_in = (count_ff == '0) ? '0 : req_position;
         REQ_REMOVE_AT: pos_in = (count_ff == CNT_W'(1)) ? '0 : req_position;
         default:       pos_in = req_position;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[ADDR_W-1:0];
      wr_data = val_ff;
      if (cmd.write_val) begin
         wr_en = 1'b1;
      end else if (cmd.walk == WALK_DOWN && rd_vld_ff && !dn_keep) begin
         wr_en   = 1'b1;
         wr_addr = lag_ff - ADDR_W'(1);
         wr_data = rdata_ff;
      end else if (cmd.walk == WALK_UP && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = lag_ff + ADDR_W'(1);
         wr_data = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      ptr_in  = ptr_ff;
      left_in = left_ff;
      if (cmd.scan_go) begin
         ptr_in = '0;
      end else if (cmd.dn_go) begin
         ptr_in = CNT_W'(pos_ff);
      end else if (cmd.dn_from_lag) begin
         ptr_in = CNT_W'(lag_ff);
      end else if (cmd.up_go) begin
         ptr_in  = count_ff - CNT_W'(1);
         left_in = ADDR_W'(count_ff - CNT_W'(pos_ff));
      end else if (issue) begin
         if (cmd.walk == WALK_UP) begin
            ptr_in  = ptr_ff - CNT_W'(1);
            left_in = left_ff - ADDR_W'(1);
         end else begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rval_in   = rval_ff;
      ridx_in   = ridx_ff;
      status_in = status_ff;
      if (cmd.load) begin
         rval_in   = '0;
         ridx_in   = NO_INDEX;
         status_in = ST_DONE;
      end else begin
         if (cmd.capture || (cmd.walk == WALK_DOWN && dn_keep)) begin
            rval_in = rdata_ff;
         end
         if (cmd.set_idx) begin
            ridx_in = IDX_W'(lag_ff);
         end
         if (cmd.set_miss) begin
            status_in = ST_MISS;
         end else if (cmd.set_full) begin
            status_in = ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      left_ff   <= left_in;
      rval_ff   <= rval_in;
      ridx_ff   <= ridx_in;
      status_ff <= status_in;
      if (rd_en) begin
         lag_ff <= rd_addr;
      end
      if (cmd.load) begin
         op_ff  <= req_type_type'(req_type);
         pos_ff <= pos_in;
         val_ff <= req_item_value;
      end else if (cmd.dn_from_lag) begin
         pos_ff <= POS_W'(lag_ff);
      end
      if (cmd.finish) begin
         rsp_value_ff  <= rval_ff;
         rsp_index_ff  <= ridx_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign stat.op         = op_ff;
   assign stat.full       = (count_ff >= CNT_W'(CAPACITY));
   assign stat.pos_le_cnt = (CNT_W'(pos_ff) <= count_ff);
   assign stat.pos_lt_cnt = (CNT_W'(pos_ff) < count_ff);
   assign stat.hit        = rd_vld_ff && (rdata_ff == val_ff);
   assign stat.fwd_more   = fwd_more;
   assign stat.up_more    = up_more;
   assign stat.rd_vld     = rd_vld_ff;

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_list_count   = rsp_count_ff;

`ifndef SYNTH
   a_one_word_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two result words back to back");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == ST_FULL) |-> (rsp_count_ff == CNT_W'(CAPACITY)))
      else $error("full status with list not full");

   a_index_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_index_ff != NO_INDEX) |-> (rsp_status_ff == ST_DONE))
      else $error("index given on a failed request");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == ST_MISS) |-> (rsp_value_ff == '0))
      else $error("value given on a failed request");
`endif

endmodule
